// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files of the box shape rule filter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset
`define BSRF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Condition that must never be seen outside reset
`define BSRF_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== src/bsrf_pkg.sv =====
// Types, constants and helper functions of the box shape rule filter
package bsrf_pkg;

   // pipeline depths
   localparam int FrontLat  = 3;
   localparam int SqrtSteps = 17;
   localparam int RulesLat  = 5;
   localparam int TotalLat  = FrontLat + SqrtSteps + RulesLat;

   // rule constants (Q8.8 where a length)
   localparam logic [16:0] SensorOffset = 17'd64;
   localparam logic [15:0] MinPoints    = 16'd30;
   localparam logic [16:0] RatioLen     = 17'd768;

   // reset values of the control registers
   localparam logic [15:0] HeightMinRst  = 16'd51;
   localparam logic [15:0] HeightMaxRst  = 16'd640;
   localparam logic [15:0] WidthMinRst   = 16'd128;
   localparam logic [15:0] WidthMaxRst   = 16'd896;
   localparam logic [15:0] LengthMinRst  = 16'd128;
   localparam logic [15:0] LengthMaxRst  = 16'd5120;
   localparam logic [31:0] AreaMaxRst    = 32'd1966080;
   localparam logic [15:0] DensityMinRst = 16'd2048;

   // register indexes
   typedef enum logic [2:0] {
      REG_HEIGHT_MIN  = 3'd0,
      REG_HEIGHT_MAX  = 3'd1,
      REG_WIDTH_MIN   = 3'd2,
      REG_WIDTH_MAX   = 3'd3,
      REG_LENGTH_MIN  = 3'd4,
      REG_LENGTH_MAX  = 3'd5,
      REG_AREA_MAX    = 3'd6,
      REG_DENSITY_MIN = 3'd7
   } reg_index_type;

   // control register set
   typedef struct packed {
      logic [15:0] height_min;
      logic [15:0] height_max;
      logic [15:0] width_min;
      logic [15:0] width_max;
      logic [15:0] length_min;
      logic [15:0] length_max;
      logic [31:0] area_max;
      logic [15:0] density_min;
   } csr_type;

   // fields carried alongside the side length datapath
   typedef struct packed {
      logic signed [16:0] height;
      logic [15:0]        count;
   } side_type;

   // squared side lengths out of the front end
   typedef struct packed {
      logic        vld;
      logic [32:0] sum_a;
      logic [32:0] sum_b;
      side_type    side;
   } front_out_type;

   // one square root stage for both sides
   typedef struct packed {
      logic [32:0] rem_a;
      logic [33:0] res_a;
      logic [32:0] rem_b;
      logic [33:0] res_b;
      side_type    side;
   } sq_stage_type;

   // both side lengths out of the square root pipe
   typedef struct packed {
      logic        vld;
      logic [16:0] d1;
      logic [16:0] d2;
      side_type    side;
   } sqrt_out_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [33:0] res;
   } root_state_type;

   // one step of the digit by digit integer square root
   function automatic root_state_type sqrt_step(input logic [32:0] rem,
                                                input logic [33:0] res,
                                                input logic [33:0] step_bit);
      root_state_type st;
      logic [33:0]    trial;
      trial = res + step_bit;
      if ({1'b0, rem} >= trial) begin
         st.rem = rem - trial[32:0];
         st.res = (res >> 1) + step_bit;
      end else begin
         st.rem = rem;
         st.res = res >> 1;
      end
      return st;
   endfunction

endpackage

// ===== src/bsrf_front.sv =====
// Front end: corner differences, squares and squared side lengths
module bsrf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  logic signed [15:0]  ax,
   input  logic signed [15:0]  ay,
   input  logic signed [15:0]  bx,
   input  logic signed [15:0]  by,
   input  logic signed [15:0]  cx,
   input  logic signed [15:0]  cy,
   input  logic signed [15:0]  top_z,
   input  logic [15:0]         count,
   output bsrf_pkg::front_out_type fo
);

   logic                  vld1_ff, vld2_ff, vld3_ff;
   logic signed [16:0]    dxa_ff, dya_ff, dxc_ff, dyc_ff;
   logic signed [16:0]    dxa_in, dya_in, dxc_in, dyc_in;
   logic [31:0]           sqxa_ff, sqya_ff, sqxc_ff, sqyc_ff;
   logic signed [33:0]    pxa, pya, pxc, pyc;
   logic [32:0]           suma_ff, sumc_ff;
   bsrf_pkg::side_type    side1_in, side1_ff, side2_ff, side3_ff;

   // stage 1: differences to the shared corner, height plus offset
   assign dxa_in = 17'({ax[15], ax}) - 17'({bx[15], bx});
   assign dya_in = 17'({ay[15], ay}) - 17'({by[15], by});
   assign dxc_in = 17'({cx[15], cx}) - 17'({bx[15], bx});
   assign dyc_in = 17'({cy[15], cy}) - 17'({by[15], by});
   assign side1_in.height = 17'({top_z[15], top_z}) + $signed(bsrf_pkg::SensorOffset);
   assign side1_in.count  = count;

   // stage 2: squares, each below 2^32
   assign pxa = dxa_ff * dxa_ff;
   assign pya = dya_ff * dya_ff;
   assign pxc = dxc_ff * dxc_ff;
   assign pyc = dyc_ff * dyc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dxa_ff   <= dxa_in;
      dya_ff   <= dya_in;
      dxc_ff   <= dxc_in;
      dyc_ff   <= dyc_in;
      side1_ff <= side1_in;
      sqxa_ff  <= pxa[31:0];
      sqya_ff  <= pya[31:0];
      sqxc_ff  <= pxc[31:0];
      sqyc_ff  <= pyc[31:0];
      side2_ff <= side1_ff;
      // stage 3: squared distances
      suma_ff  <= {1'b0, sqxa_ff} + {1'b0, sqya_ff};
      sumc_ff  <= {1'b0, sqxc_ff} + {1'b0, sqyc_ff};
      side3_ff <= side2_ff;
   end

   assign fo.vld   = vld3_ff;
   assign fo.sum_a = suma_ff;
   assign fo.sum_b = sumc_ff;
   assign fo.side  = side3_ff;

endmodule

// ===== src/bsrf_sqrt.sv =====
// Pipelined integer square root of both squared side lengths, one bit a stage
module bsrf_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  bsrf_pkg::front_out_type fi,
   output bsrf_pkg::sqrt_out_type  so
);

   localparam int Steps = bsrf_pkg::SqrtSteps;

   bsrf_pkg::sq_stage_type stg_ff [Steps];
   logic                   vld_ff [Steps];

   genvar k;
   generate
      for (k = 0; k < Steps; k++) begin : g_step
         localparam logic [33:0] StepBit = 34'(1) << (2 * (Steps - 1 - k));
         bsrf_pkg::sq_stage_type   cur_s, stg_in;
         bsrf_pkg::root_state_type ra, rb;
         logic                     vld_cur;

         // stage input: squared sums on the first step, previous stage after
         if (k == 0) begin : g_first
            always_comb begin
               cur_s.rem_a = fi.sum_a;
               cur_s.res_a = '0;
               cur_s.rem_b = fi.sum_b;
               cur_s.res_b = '0;
               cur_s.side  = fi.side;
               vld_cur     = fi.vld;
            end
         end else begin : g_next
            always_comb begin
               cur_s   = stg_ff[k-1];
               vld_cur = vld_ff[k-1];
            end
         end

         // one root bit per side
         always_comb begin
            ra = bsrf_pkg::sqrt_step(cur_s.rem_a, cur_s.res_a, StepBit);
            rb = bsrf_pkg::sqrt_step(cur_s.rem_b, cur_s.res_b, StepBit);
            stg_in.rem_a = ra.rem;
            stg_in.res_a = ra.res;
            stg_in.rem_b = rb.rem;
            stg_in.res_b = rb.res;
            stg_in.side  = cur_s.side;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= vld_cur;
            end
         end

         always_ff @(posedge clock) begin
            stg_ff[k] <= stg_in;
         end
      end
   endgenerate

   // roots are below 2^17
   assign so.vld  = vld_ff[Steps-1];
   assign so.d1   = stg_ff[Steps-1].res_a[16:0];
   assign so.d2   = stg_ff[Steps-1].res_b[16:0];
   assign so.side = stg_ff[Steps-1].side;

endmodule

// ===== src/bsrf_rules.sv =====
// Shape rules: length/width pick, area, bound checks, density and ratio tests
module bsrf_rules (
   input  logic                   clock,
   input  logic                   reset,
   input  bsrf_pkg::sqrt_out_type si,
   input  bsrf_pkg::csr_type      csr,
   output logic                   rsp_valid,
   output logic                   rsp_is_promising,
   output logic [16:0]            rsp_box_length,
   output logic [16:0]            rsp_box_width,
   output logic signed [16:0]     rsp_box_height
);

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [16:0]         len1_ff, wid1_ff, len2_ff, wid2_ff, len3_ff, wid3_ff;
   logic [16:0]         len4_ff, wid4_ff, len5_ff, wid5_ff;
   logic [33:0]         area1_ff;
   bsrf_pkg::side_type  side1_ff, side2_ff, side3_ff, side4_ff;
   logic signed [16:0]  hgt5_ff;
   logic                bounds_ok, ratio_ok;
   logic                pre2_ff, pre3_ff, pre4_ff;
   logic                rat2_ff, rat3_ff, rat4_ff;
   logic [47:0]         ah2_ff;
   logic [47:0]         plo3_ff;
   logic [31:0]         phi3_ff;
   logic [63:0]         need4_ff;
   logic                ok5_ff;
   logic [17:0]         wid_x2;
   logic [19:0]         wid_x8;
   logic signed [17:0]  h_s, hmin_s, hmax_s;
   logic [63:0]         cnt_sh;

   // stage 2 checks on the picked sides
   always_comb begin
      h_s    = {side1_ff.height[16], side1_ff.height};
      hmin_s = $signed({2'b00, csr.height_min});
      hmax_s = $signed({2'b00, csr.height_max});
      bounds_ok = (side1_ff.count >= bsrf_pkg::MinPoints) &&
                  (h_s > hmin_s) && (h_s < hmax_s) &&
                  (wid1_ff > {1'b0, csr.width_min}) &&
                  (wid1_ff < {1'b0, csr.width_max}) &&
                  (len1_ff > {1'b0, csr.length_min}) &&
                  (len1_ff < {1'b0, csr.length_max}) &&
                  (area1_ff < {2'b00, csr.area_max});
      wid_x2   = {wid1_ff, 1'b0};
      wid_x8   = {wid1_ff, 3'b000};
      ratio_ok = (len1_ff <= bsrf_pkg::RatioLen) ||
                 (({1'b0, len1_ff} > wid_x2) && ({3'b000, len1_ff} < wid_x8));
   end

   // stage 5 density compare: count in Q32 against the needed product
   assign cnt_sh = {side4_ff.count, 48'd0} >> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= si.vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      // stage 1: longer side is the length, product of sides is the area
      len1_ff  <= (si.d1 > si.d2) ? si.d1 : si.d2;
      wid1_ff  <= (si.d1 > si.d2) ? si.d2 : si.d1;
      area1_ff <= si.d1 * si.d2;
      side1_ff <= si.side;
      // stage 2: bounds, ratio, area times height (both fit when bounds hold)
      pre2_ff  <= bounds_ok;
      rat2_ff  <= ratio_ok;
      ah2_ff   <= area1_ff[31:0] * side1_ff.height[15:0];
      len2_ff  <= len1_ff;
      wid2_ff  <= wid1_ff;
      side2_ff <= side1_ff;
      // stage 3: times density, as two partial products
      plo3_ff  <= ah2_ff[31:0] * csr.density_min;
      phi3_ff  <= ah2_ff[47:32] * csr.density_min;
      pre3_ff  <= pre2_ff;
      rat3_ff  <= rat2_ff;
      len3_ff  <= len2_ff;
      wid3_ff  <= wid2_ff;
      side3_ff <= side2_ff;
      // stage 4: join the partial products
      need4_ff <= {phi3_ff, 32'd0} + {16'd0, plo3_ff};
      pre4_ff  <= pre3_ff;
      rat4_ff  <= rat3_ff;
      len4_ff  <= len3_ff;
      wid4_ff  <= wid3_ff;
      side4_ff <= side3_ff;
      // stage 5: final verdict into the output register
      ok5_ff   <= pre4_ff && rat4_ff && (cnt_sh > need4_ff);
      len5_ff  <= len4_ff;
      wid5_ff  <= wid4_ff;
      hgt5_ff  <= side4_ff.height;
   end

   assign rsp_valid        = v5_ff;
   assign rsp_is_promising = ok5_ff;
   assign rsp_box_length   = len5_ff;
   assign rsp_box_width    = wid5_ff;
   assign rsp_box_height   = hgt5_ff;

endmodule

// ===== src/box_shape_rule_filter.sv =====
// Top level of the box shape rule filter: control registers and pipeline
//
//   channel   direction   handshake                 word
//   req_*     in          start high, busy low      three corners, top z, count
//   rsp_*     out         rsp_valid, one cycle      verdict, length, width, height
//   csr_*     in          csr_valid and csr_ready   register index and data
//
// One box is taken every cycle; its result leaves through the front, square root and rule stages.
// The depth is set by the square root pipe, one root bit per stage (17 stages),
// plus three front stages (differences, squares, sums) and five rule stages.
// busy stays low: the pipeline never stops, and neither side can stall it.
// Reset empties the pipeline and loads the register defaults; results of
// boxes in flight at reset are dropped.
`include "assert_macros.svh"

module box_shape_rule_filter (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_corner_a_x,
   input  logic signed [15:0] req_corner_a_y,
   input  logic signed [15:0] req_corner_b_x,
   input  logic signed [15:0] req_corner_b_y,
   input  logic signed [15:0] req_corner_c_x,
   input  logic signed [15:0] req_corner_c_y,
   input  logic signed [15:0] req_top_z,
   input  logic [15:0]        req_point_count,
   output logic               rsp_valid,
   output logic               rsp_is_promising,
   output logic [16:0]        rsp_box_length,
   output logic [16:0]        rsp_box_width,
   output logic signed [16:0] rsp_box_height,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   bsrf_pkg::csr_type       csr_ff;
   bsrf_pkg::front_out_type front_o;
   bsrf_pkg::sqrt_out_type  sqrt_o;
   logic                    accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.height_min  <= bsrf_pkg::HeightMinRst;
         csr_ff.height_max  <= bsrf_pkg::HeightMaxRst;
         csr_ff.width_min   <= bsrf_pkg::WidthMinRst;
         csr_ff.width_max   <= bsrf_pkg::WidthMaxRst;
         csr_ff.length_min  <= bsrf_pkg::LengthMinRst;
         csr_ff.length_max  <= bsrf_pkg::LengthMaxRst;
         csr_ff.area_max    <= bsrf_pkg::AreaMaxRst;
         csr_ff.density_min <= bsrf_pkg::DensityMinRst;
      end else if (csr_valid && csr_ready) begin
         case (bsrf_pkg::reg_index_type'(csr_index))
            bsrf_pkg::REG_HEIGHT_MIN:  csr_ff.height_min  <= csr_wdata[15:0];
            bsrf_pkg::REG_HEIGHT_MAX:  csr_ff.height_max  <= csr_wdata[15:0];
            bsrf_pkg::REG_WIDTH_MIN:   csr_ff.width_min   <= csr_wdata[15:0];
            bsrf_pkg::REG_WIDTH_MAX:   csr_ff.width_max   <= csr_wdata[15:0];
            bsrf_pkg::REG_LENGTH_MIN:  csr_ff.length_min  <= csr_wdata[15:0];
            bsrf_pkg::REG_LENGTH_MAX:  csr_ff.length_max  <= csr_wdata[15:0];
            bsrf_pkg::REG_AREA_MAX:    csr_ff.area_max    <= csr_wdata;
            bsrf_pkg::REG_DENSITY_MIN: csr_ff.density_min <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   bsrf_front u_front (
      .clock (clock),
      .reset (reset),
      .in_vld(accept),
      .ax    (req_corner_a_x),
      .ay    (req_corner_a_y),
      .bx    (req_corner_b_x),
      .by    (req_corner_b_y),
      .cx    (req_corner_c_x),
      .cy    (req_corner_c_y),
      .top_z (req_top_z),
      .count (req_point_count),
      .fo    (front_o)
   );

   bsrf_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .fi   (front_o),
      .so   (sqrt_o)
   );

   bsrf_rules u_rules (
      .clock           (clock),
      .reset           (reset),
      .si              (sqrt_o),
      .csr             (csr_ff),
      .rsp_valid       (rsp_valid),
      .rsp_is_promising(rsp_is_promising),
      .rsp_box_length  (rsp_box_length),
      .rsp_box_width   (rsp_box_width),
      .rsp_box_height  (rsp_box_height)
   );

   // every result stems from a box taken exactly one pipeline depth earlier
   `BSRF_ASSERT_IMPL(a_rsp_from_req, clock, reset, rsp_valid,
                     $past(accept, bsrf_pkg::TotalLat))
   // the longer side is never reported shorter than the width
   `BSRF_ASSERT_NEVER(a_len_ge_wid, clock, reset,
                      rsp_valid && (rsp_box_length < rsp_box_width))
   // a passing box has positive height and nonzero width
   `BSRF_ASSERT_IMPL(a_pass_sane, clock, reset, rsp_valid && rsp_is_promising,
                     !rsp_box_height[16] && (rsp_box_height != 17'sd0) &&
                     (rsp_box_width != 17'd0))

endmodule

// ===== verif/box_shape_rule_filter_tb.sv =====
// Self-checking testbench of the box shape rule filter: directed and random boxes
module box_shape_rule_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64_type;

   // shape rule constants, Q8.8 where a length
   localparam longint OffsetQ8    = 64;
   localparam longint MinCount    = 30;
   localparam longint RatioGateQ8 = 768;

   // one request word
   typedef struct {
      logic signed [15:0] ax, ay, bx, by, cx, cy;
      logic signed [15:0] top_z;
      logic [15:0]        count;
   } box_word_type;

   // one result word
   typedef struct {
      logic               promising;
      logic [16:0]        length;
      logic [16:0]        width;
      logic signed [16:0] height;
   } verdict_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_corner_a_x;
   logic signed [15:0] req_corner_a_y;
   logic signed [15:0] req_corner_b_x;
   logic signed [15:0] req_corner_b_y;
   logic signed [15:0] req_corner_c_x;
   logic signed [15:0] req_corner_c_y;
   logic signed [15:0] req_top_z;
   logic [15:0]        req_point_count;
   logic               rsp_valid;
   logic               rsp_is_promising;
   logic [16:0]        rsp_box_length;
   logic [16:0]        rsp_box_width;
   logic signed [16:0] rsp_box_height;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   bsrf_pkg::csr_type rules;                // shadow of the control registers
   verdict_type       pending_verdicts[$];  // verdicts still to come out, oldest first
   int                mismatch_count = 0;
   int                boxes_sent     = 0;
   int                verdicts_seen  = 0;
   int                promising_seen = 0;
   int                settings_used  = 0;
   int                burst_left     = 0;

   box_shape_rule_filter uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_corner_a_x   (req_corner_a_x),
      .req_corner_a_y   (req_corner_a_y),
      .req_corner_b_x   (req_corner_b_x),
      .req_corner_b_y   (req_corner_b_y),
      .req_corner_c_x   (req_corner_c_x),
      .req_corner_c_y   (req_corner_c_y),
      .req_top_z        (req_top_z),
      .req_point_count  (req_point_count),
      .rsp_valid        (rsp_valid),
      .rsp_is_promising (rsp_is_promising),
      .rsp_box_length   (rsp_box_length),
      .rsp_box_width    (rsp_box_width),
      .rsp_box_height   (rsp_box_height),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   // floor of the square root, one result bit at a time from the top
   function automatic u64_type floor_root(input u64_type v);
      u64_type r;
      u64_type t;
      r = 0;
      for (int b = 17; b >= 0; b--) begin
         t = r | (u64_type'(1) << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic u64_type side_of(input logic signed [15:0] x1, y1, x2, y2);
      longint dx;
      longint dy;
      dx = longint'(x1) - longint'(x2);
      dy = longint'(y1) - longint'(y2);
      return floor_root(u64_type'(dx * dx + dy * dy));
   endfunction

   function automatic verdict_type judge_box(input box_word_type b);
      verdict_type v;
      u64_type     d1, d2, len, wid, area, need, cnt;
      longint      height;
      logic        ok;
      d1     = side_of(b.ax, b.ay, b.bx, b.by);
      d2     = side_of(b.cx, b.cy, b.bx, b.by);
      len    = (d1 > d2) ? d1 : d2;
      wid    = (d1 > d2) ? d2 : d1;
      area   = d1 * d2;
      height = longint'(b.top_z) + OffsetQ8;
      cnt    = u64_type'(b.count);
      ok     = 1'b0;
      // signed height against unsigned bounds: negative height never passes
      if (cnt >= u64_type'(MinCount) &&
          height > longint'(rules.height_min) && height < longint'(rules.height_max) &&
          wid > u64_type'(rules.width_min) && wid < u64_type'(rules.width_max) &&
          len > u64_type'(rules.length_min) && len < u64_type'(rules.length_max) &&
          area < u64_type'(rules.area_max)) begin
         // Q16.16 area x Q8.8 height x Q8.8 density against Q32.32 count
         need = area * u64_type'(height) * u64_type'(rules.density_min);
         if ((cnt << 32) > need) begin
            if (len > u64_type'(RatioGateQ8)) ok = (len > 2 * wid) && (len < 8 * wid);
            else ok = 1'b1;
         end
      end
      v.promising = ok;
      v.length    = len[16:0];
      v.width     = wid[16:0];
      v.height    = height[16:0];
      return v;
   endfunction

   function automatic bsrf_pkg::csr_type reset_rules();
      bsrf_pkg::csr_type c;
      c.height_min  = 16'd51;
      c.height_max  = 16'd640;
      c.width_min   = 16'd128;
      c.width_max   = 16'd896;
      c.length_min  = 16'd128;
      c.length_max  = 16'd5120;
      c.area_max    = 32'd1966080;
      c.density_min = 16'd2048;
      return c;
   endfunction

   // ---------------------------------------------------------------- checking

   // each result word against the oldest outstanding verdict
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $error("result with no box outstanding: length %0d width %0d",
                   rsp_box_length, rsp_box_width);
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            verdicts_seen++;
            if (want.promising) promising_seen++;
            if (rsp_is_promising !== want.promising) begin
               $error("is_promising: expected %0b, got %0b", want.promising, rsp_is_promising);
               mismatch_count++;
            end
            if (rsp_box_length !== want.length) begin
               $error("box_length: expected %0d, got %0d", want.length, rsp_box_length);
               mismatch_count++;
            end
            if (rsp_box_width !== want.width) begin
               $error("box_width: expected %0d, got %0d", want.width, rsp_box_width);
               mismatch_count++;
            end
            if (rsp_box_height !== want.height) begin
               $error("box_height: expected %0d, got %0d", want.height, rsp_box_height);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // one request word; bursts of random length with random gaps between them
   task automatic offer_box(input box_word_type b);
      start           <= 1'b1;
      req_corner_a_x  <= b.ax;
      req_corner_a_y  <= b.ay;
      req_corner_b_x  <= b.bx;
      req_corner_b_y  <= b.by;
      req_corner_c_x  <= b.cx;
      req_corner_c_y  <= b.cy;
      req_top_z       <= b.top_z;
      req_point_count <= b.count;
      do @(posedge clock); while (busy !== 1'b0);
      pending_verdicts.insert(pending_verdicts.size(), judge_box(b));
      boxes_sent++;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(0, 24);
      end else begin
         burst_left--;
      end
   endtask

   // stop sending and wait for every outstanding verdict
   task automatic settle();
      if (start) start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // csr_valid is left high; the caller lowers it after the last write
   task automatic write_reg(input bsrf_pkg::reg_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         bsrf_pkg::REG_HEIGHT_MIN:  rules.height_min  = data[15:0];
         bsrf_pkg::REG_HEIGHT_MAX:  rules.height_max  = data[15:0];
         bsrf_pkg::REG_WIDTH_MIN:   rules.width_min   = data[15:0];
         bsrf_pkg::REG_WIDTH_MAX:   rules.width_max   = data[15:0];
         bsrf_pkg::REG_LENGTH_MIN:  rules.length_min  = data[15:0];
         bsrf_pkg::REG_LENGTH_MAX:  rules.length_max  = data[15:0];
         bsrf_pkg::REG_AREA_MAX:    rules.area_max    = data;
         bsrf_pkg::REG_DENSITY_MIN: rules.density_min = data[15:0];
         default: ;
      endcase
   endtask

   // whole register set; random upper bits on the 16 bit registers must be dropped
   task automatic load_rules(input bsrf_pkg::csr_type c);
      settle();
      write_reg(bsrf_pkg::REG_HEIGHT_MIN,  {16'($urandom), c.height_min});
      write_reg(bsrf_pkg::REG_HEIGHT_MAX,  {16'($urandom), c.height_max});
      write_reg(bsrf_pkg::REG_WIDTH_MIN,   {16'($urandom), c.width_min});
      write_reg(bsrf_pkg::REG_WIDTH_MAX,   {16'($urandom), c.width_max});
      write_reg(bsrf_pkg::REG_LENGTH_MIN,  {16'($urandom), c.length_min});
      write_reg(bsrf_pkg::REG_LENGTH_MAX,  {16'($urandom), c.length_max});
      write_reg(bsrf_pkg::REG_AREA_MAX,    c.area_max);
      write_reg(bsrf_pkg::REG_DENSITY_MIN, {16'($urandom), c.density_min});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic int spread(input int r);
      int pick;
      pick = $urandom_range(0, 2 * r);
      return pick - r;
   endfunction

   // axis aligned box: side AB along x, side CB along y
   function automatic box_word_type axis_box(input int la, input int lc, input int top,
                                             input int cnt);
      box_word_type b;
      b.bx    = 16'(-1500);
      b.by    = 16'(2500);
      b.ax    = 16'(-1500 + la);
      b.ay    = 16'(2500);
      b.cx    = 16'(-1500);
      b.cy    = 16'(2500 - lc);
      b.top_z = 16'(top);
      b.count = 16'(cnt);
      return b;
   endfunction

   // plausible box: sides up to about 14 m, heights around the default bounds
   function automatic box_word_type shaped_box();
      box_word_type b;
      int           x0, y0, la, lc;
      x0 = spread(28000);
      y0 = spread(28000);
      la = $urandom_range(0, 2600);
      lc = $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom_range(0, 2600);
      b.bx    = 16'(x0);
      b.by    = 16'(y0);
      b.ax    = 16'(x0 + spread(la));
      b.ay    = 16'(y0 + spread(la));
      b.cx    = 16'(x0 + spread(lc));
      b.cy    = 16'(y0 + spread(lc));
      b.top_z = 16'(spread(450) + 330);
      case ($urandom_range(0, 3))
         0:       b.count = 16'($urandom_range(0, 40));
         1, 2:    b.count = 16'($urandom_range(20, 1500));
         default: b.count = 16'($urandom);
      endcase
      return b;
   endfunction

   // mostly plausible boxes, the rest fully random words
   function automatic box_word_type mixed_box();
      box_word_type b;
      if ($urandom_range(0, 4) != 0) return shaped_box();
      b.ax    = 16'($urandom);
      b.ay    = 16'($urandom);
      b.bx    = 16'($urandom);
      b.by    = 16'($urandom);
      b.cx    = 16'($urandom);
      b.cy    = 16'($urandom);
      b.top_z = 16'($urandom);
      b.count = 16'($urandom);
      return b;
   endfunction

   function automatic bsrf_pkg::csr_type loose_rules();
      bsrf_pkg::csr_type c;
      if ($urandom_range(0, 3) == 0) begin
         c.height_min  = 16'($urandom);
         c.height_max  = 16'($urandom);
         c.width_min   = 16'($urandom);
         c.width_max   = 16'($urandom);
         c.length_min  = 16'($urandom);
         c.length_max  = 16'($urandom);
         c.area_max    = $urandom;
         c.density_min = 16'($urandom);
      end else begin
         c.height_min  = 16'($urandom_range(0, 200));
         c.height_max  = 16'($urandom_range(200, 1200));
         c.width_min   = 16'($urandom_range(0, 300));
         c.width_max   = 16'($urandom_range(300, 2000));
         c.length_min  = 16'($urandom_range(0, 700));
         c.length_max  = 16'($urandom_range(1000, 8000));
         c.area_max    = $urandom_range(200000, 10000000);
         c.density_min = 16'($urandom_range(0, 6000));
      end
      return c;
   endfunction

   // ---------------------------------------------------------------- tests

   // boundary boxes under the reset register values
   task automatic test_directed();
      box_word_type b;
      b = '{default: '0};
      offer_box(b);                                  // all zero: no sides, few points
      b = '{ax: 16'sh8000, ay: 16'sh8000, bx: 16'sh7FFF, by: 16'sh7FFF,
            cx: 16'sh8000, cy: 16'sh7FFF, top_z: 16'sh7FFF, count: 16'hFFFF};
      offer_box(b);                                  // largest sides and height
      b = '{ax: 16'sh7FFF, ay: 16'sh8000, bx: 16'sh8000, by: 16'sh7FFF,
            cx: 16'sh7FFF, cy: 16'sh7FFF, top_z: 16'sh8000, count: 16'd0};
      offer_box(b);                                  // lowest height, no points
      offer_box(axis_box(512, 384, 320, 200));       // short box, passes
      offer_box(axis_box(384, 512, 320, 200));       // same box, sides swapped
      offer_box(axis_box(256, 256, 192, 30));        // equal sides, least count that passes
      offer_box(axis_box(256, 256, 192, 29));        // one point too few
      offer_box(axis_box(1024, 256, 320, 500));      // long box, ratio 4
      offer_box(axis_box(1024, 640, 320, 2000));     // ratio below 2
      offer_box(axis_box(1024, 512, 320, 2000));     // ratio exactly 2
      offer_box(axis_box(2560, 307, 320, 2000));     // ratio above 8
      offer_box(axis_box(2048, 256, 320, 2000));     // ratio exactly 8
      offer_box(axis_box(2047, 256, 320, 2000));     // ratio just under 8
      offer_box(axis_box(768, 700, 320, 2000));      // 3 m long: no ratio test
      offer_box(axis_box(769, 700, 320, 2000));      // just over 3 m: ratio test fails
      offer_box(axis_box(512, 384, -200, 2000));     // negative height
      offer_box(axis_box(512, 384, -13, 2000));      // height on the lower bound
      offer_box(axis_box(512, 384, -12, 2000));      // height just above it
      offer_box(axis_box(512, 384, 576, 2000));      // height on the upper bound
      offer_box(axis_box(512, 128, 320, 2000));      // width on the lower bound
      offer_box(axis_box(512, 129, 320, 2000));      // width just above it
      offer_box(axis_box(512, 0, 320, 2000));        // zero width
      offer_box(axis_box(512, 512, 448, 31));        // too sparse for the density rule
      b = '{ax: 16'sd1, ay: 16'sd1, bx: 16'sd0, by: 16'sd0, cx: -16'sd300, cy: 16'sd400,
            top_z: 16'sd100, count: 16'd100};
      offer_box(b);                                  // root rounded down
      settle();
   endtask

   // all-zero, wide-open and all-ones register settings
   task automatic test_register_extremes();
      bsrf_pkg::csr_type c;
      c = '0;
      load_rules(c);
      repeat (40) offer_box(mixed_box());
      c = '1;
      c.height_min  = '0;
      c.width_min   = '0;
      c.length_min  = '0;
      c.density_min = '0;
      load_rules(c);
      repeat (40) offer_box(mixed_box());
      c = '1;
      load_rules(c);
      repeat (40) offer_box(mixed_box());
   endtask

   task automatic test_random_settings();
      repeat (12) begin
         load_rules(loose_rules());
         repeat (105) offer_box(mixed_box());
      end
   endtask

   task automatic test_back_to_defaults();
      load_rules(reset_rules());
      repeat (80) offer_box(mixed_box());
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      rules           = reset_rules();
      reset           <= 1'b1;
      start           <= 1'b0;
      req_corner_a_x  <= '0;
      req_corner_a_y  <= '0;
      req_corner_b_x  <= '0;
      req_corner_b_y  <= '0;
      req_corner_c_x  <= '0;
      req_corner_c_y  <= '0;
      req_top_z       <= '0;
      req_point_count <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= bsrf_pkg::REG_HEIGHT_MIN;
      csr_wdata       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_random_settings();
      test_back_to_defaults();

      // drain, then watch the pipeline depth for stray results
      settle();
      repeat (bsrf_pkg::TotalLat + 4) @(posedge clock);
      $display("Summary: %0d boxes sent, %0d verdicts checked, %0d promising",
               boxes_sent, verdicts_seen, promising_seen);
      $display("Register settings loaded: %0d, from all-zero to all-ones bounds",
               settings_used);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // run limit
   initial begin
      #(4_000_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/bsrf_pkg.sv
src/bsrf_front.sv
src/bsrf_sqrt.sv
src/bsrf_rules.sv
src/box_shape_rule_filter.sv
verif/box_shape_rule_filter_tb.sv
